[hw/rtl/pls_pkg.sv]
// Package for the positional list store: sizes, command codes and the
// memory request structure shared by the sequencer and the item RAM.
// No dependencies.
package pls_pkg;

    // List capacity and derived widths
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the word interface
    localparam int CMD_W  = 3;
    localparam int POS_W  = 9;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 10;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT_AT     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT_SORTED = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE_AT      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE_ALL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GET           = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SET           = 3'd5;
    localparam logic [CMD_W-1:0] CMD_FIND          = 3'd6;

    // Index result meaning "none" / "list full"
    localparam logic [IDX_W-1:0] IDX_NONE = '1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [DATA_W-1:0] t_data;

    // One write port and one read port per cycle
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_data wdata;
        logic  re;
        t_addr raddr;
    } t_ram_req;

endpackage

[hw/rtl/pls_ram.sv]
// Item storage for the positional list store: simple dual-port RAM with
// one write and one registered read per cycle.
// Depends on pls_pkg.
module pls_ram (
    input  logic              i_clk,
    input  pls_pkg::t_ram_req i_req,
    output pls_pkg::t_data    o_rdata
);

    pls_pkg::t_data mem [pls_pkg::CAPACITY];
    pls_pkg::t_data r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/pls_seq.sv]
// Command sequencer for the positional list store: walks the item RAM one
// entry per cycle through a single compare unit, shifts and compacts entries,
// and holds the result word register. Depends on pls_pkg.
module pls_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [pls_pkg::CMD_W-1:0]   i_command,
    input  logic [pls_pkg::POS_W-1:0]   i_position,
    input  logic signed [pls_pkg::DATA_W-1:0] i_item_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_ok,
    output logic signed [pls_pkg::IDX_W-1:0]  o_index_result,
    output logic signed [pls_pkg::DATA_W-1:0] o_read_value,
    output logic [pls_pkg::CNT_W-1:0]   o_item_count,
    output logic                        o_is_empty,
    output pls_pkg::t_ram_req           o_ram_req,
    input  pls_pkg::t_data              i_ram_rdata
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_UP   = 3'd2;
    localparam logic [2:0] S_DN   = 3'd3;
    localparam logic [2:0] S_REM  = 3'd4;
    localparam logic [2:0] S_FIND = 3'd5;
    localparam logic [2:0] S_GET  = 3'd6;

    localparam pls_pkg::t_cnt CAP = pls_pkg::CNT_W'(pls_pkg::CAPACITY);

    logic [2:0]                  r_state, n_state;
    pls_pkg::t_cnt               r_count, n_count;
    pls_pkg::t_cnt               r_ptr, n_ptr;
    pls_pkg::t_cnt               r_pos, n_pos;
    pls_pkg::t_cnt               r_j, n_j;
    logic [pls_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                        r_sorted, n_sorted;
    logic                        r_pend, n_pend;
    pls_pkg::t_addr              r_pend_addr, n_pend_addr;
    pls_pkg::t_data              r_val, n_val;

    logic                        r_out_valid, n_out_valid;
    logic                        r_out_ok, n_out_ok;
    logic [pls_pkg::IDX_W-1:0]   r_out_idx, n_out_idx;
    pls_pkg::t_data              r_out_rd, n_out_rd;
    pls_pkg::t_cnt               r_out_cnt, n_out_cnt;

    logic                        out_free;
    logic                        fin;
    logic                        f_ok;
    logic [pls_pkg::IDX_W-1:0]   f_idx;
    pls_pkg::t_data              f_rd;
    pls_pkg::t_cnt               f_cnt;
    logic                        cmp_eq, cmp_gt;
    pls_pkg::t_cnt               pos_cnt;
    pls_pkg::t_ram_req           ram_req;

    // Shared compare unit against the item of the current command
    assign cmp_eq  = (i_ram_rdata == r_val);
    assign cmp_gt  = ($signed(r_val) > $signed(i_ram_rdata));
    assign pos_cnt = pls_pkg::CNT_W'(i_position);

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_pos       = r_pos;
        n_j         = r_j;
        n_idx       = r_idx;
        n_sorted    = r_sorted;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_val       = r_val;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_idx   = r_out_idx;
        n_out_rd    = r_out_rd;
        n_out_cnt   = r_out_cnt;
        ram_req     = '0;
        fin         = 1'b0;
        f_ok        = 1'b0;
        f_idx       = '0;
        f_rd        = '0;
        f_cnt       = r_count;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && out_free) begin
                    n_val    = pls_pkg::t_data'(i_item_value);
                    n_pend   = 1'b0;
                    n_sorted = 1'b0;
                    unique case (i_command)
                        pls_pkg::CMD_INSERT_AT: begin
                            if (r_count < CAP && pos_cnt <= r_count) begin
                                n_pos   = pos_cnt;
                                n_ptr   = r_count;
                                n_state = S_UP;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        pls_pkg::CMD_INSERT_SORTED: begin
                            if (r_count >= CAP) begin
                                fin   = 1'b1;
                                f_idx = pls_pkg::IDX_NONE;
                            end else begin
                                n_sorted = 1'b1;
                                n_ptr    = '0;
                                n_state  = S_SCAN;
                            end
                        end
                        pls_pkg::CMD_ERASE_AT: begin
                            if (pos_cnt < r_count) begin
                                n_ptr   = pos_cnt + 1'b1;
                                n_state = S_DN;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        pls_pkg::CMD_REMOVE_ALL: begin
                            n_ptr   = '0;
                            n_j     = '0;
                            n_state = S_REM;
                        end
                        pls_pkg::CMD_GET: begin
                            if (pos_cnt < r_count) begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = pls_pkg::ADDR_W'(i_position);
                                n_state       = S_GET;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        pls_pkg::CMD_SET: begin
                            fin = 1'b1;
                            if (pos_cnt < r_count) begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = pls_pkg::ADDR_W'(i_position);
                                ram_req.wdata = pls_pkg::t_data'(i_item_value);
                                f_ok          = 1'b1;
                            end
                        end
                        pls_pkg::CMD_FIND: begin
                            n_ptr   = '0;
                            n_idx   = pls_pkg::IDX_NONE;
                            n_state = S_FIND;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            // Sorted insert: find first entry not less than the value
            S_SCAN: begin
                if (r_pend && !cmp_gt) begin
                    n_pos   = pls_pkg::CNT_W'(r_pend_addr);
                    n_ptr   = r_count;
                    n_pend  = 1'b0;
                    n_state = S_UP;
                end else if (r_ptr < r_count) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = pls_pkg::ADDR_W'(r_ptr);
                    n_ptr         = r_ptr + 1'b1;
                    n_pend        = 1'b1;
                    n_pend_addr   = pls_pkg::ADDR_W'(r_ptr);
                end else if (!r_pend) begin
                    n_pos   = r_count;
                    n_ptr   = r_count;
                    n_state = S_UP;
                end else begin
                    n_pend = 1'b0;
                end
            end

            // Shift entries [pos, count) up by one, top first, then place the item
            S_UP: begin
                if (r_pend) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = r_pend_addr + 1'b1;
                    ram_req.wdata = i_ram_rdata;
                end
                if (r_ptr > r_pos) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = pls_pkg::ADDR_W'(r_ptr - 1'b1);
                    n_ptr         = r_ptr - 1'b1;
                    n_pend        = 1'b1;
                    n_pend_addr   = pls_pkg::ADDR_W'(r_ptr - 1'b1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend && out_free) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = pls_pkg::ADDR_W'(r_pos);
                        ram_req.wdata = r_val;
                        fin           = 1'b1;
                        f_ok          = 1'b1;
                        f_idx         = r_sorted ? pls_pkg::IDX_W'(r_pos) : '0;
                        f_cnt         = r_count + 1'b1;
                    end
                end
            end

            // Shift entries above pos down by one, bottom first
            S_DN: begin
                if (r_pend) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = r_pend_addr - 1'b1;
                    ram_req.wdata = i_ram_rdata;
                end
                if (r_ptr < r_count) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = pls_pkg::ADDR_W'(r_ptr);
                    n_ptr         = r_ptr + 1'b1;
                    n_pend        = 1'b1;
                    n_pend_addr   = pls_pkg::ADDR_W'(r_ptr);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend && out_free) begin
                        fin   = 1'b1;
                        f_ok  = 1'b1;
                        f_cnt = r_count - 1'b1;
                    end
                end
            end

            // Compact: keep every entry that differs from the value
            S_REM: begin
                if (r_pend && !cmp_eq) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pls_pkg::ADDR_W'(r_j);
                    ram_req.wdata = i_ram_rdata;
                    n_j           = r_j + 1'b1;
                end
                if (r_ptr < r_count) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = pls_pkg::ADDR_W'(r_ptr);
                    n_ptr         = r_ptr + 1'b1;
                    n_pend        = 1'b1;
                    n_pend_addr   = pls_pkg::ADDR_W'(r_ptr);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend && out_free) begin
                        fin   = 1'b1;
                        f_ok  = 1'b1;
                        f_idx = pls_pkg::IDX_W'(r_count - r_j);
                        f_cnt = r_j;
                    end
                end
            end

            // Find: remember the last matching position
            S_FIND: begin
                if (r_pend && cmp_eq) begin
                    n_idx = pls_pkg::IDX_W'(r_pend_addr);
                end
                if (r_ptr < r_count) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = pls_pkg::ADDR_W'(r_ptr);
                    n_ptr         = r_ptr + 1'b1;
                    n_pend        = 1'b1;
                    n_pend_addr   = pls_pkg::ADDR_W'(r_ptr);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend && out_free) begin
                        fin   = 1'b1;
                        f_ok  = 1'b1;
                        f_idx = r_idx;
                    end
                end
            end

            // Get: read data is held by the RAM until the result slot frees
            S_GET: begin
                if (out_free) begin
                    fin  = 1'b1;
                    f_ok = 1'b1;
                    f_rd = i_ram_rdata;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the result word
        if (fin) begin
            n_state     = S_IDLE;
            n_count     = f_cnt;
            n_out_valid = 1'b1;
            n_out_ok    = f_ok;
            n_out_idx   = f_idx;
            n_out_rd    = f_rd;
            n_out_cnt   = f_cnt;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_pos       <= n_pos;
        r_j         <= n_j;
        r_idx       <= n_idx;
        r_sorted    <= n_sorted;
        r_pend_addr <= n_pend_addr;
        r_val       <= n_val;
        r_out_ok    <= n_out_ok;
        r_out_idx   <= n_out_idx;
        r_out_rd    <= n_out_rd;
        r_out_cnt   <= n_out_cnt;
    end

    assign o_ram_req      = ram_req;
    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_out_ok;
    assign o_index_result = $signed(r_out_idx);
    assign o_read_value   = $signed(r_out_rd);
    assign o_item_count   = r_out_cnt;
    assign o_is_empty     = (r_out_cnt == '0);

endmodule

[hw/rtl/positional_list_store.sv]
// Positional list store: bounded ordered list of signed 32-bit items.
//
// Input channel (i_in_valid / o_in_ready) takes one command word: command,
// position, item_value. Output channel (o_out_valid / i_out_ready) returns one
// result word per command: ok, index_result, read_value, item_count, is_empty.
//
// One command is worked at a time; o_in_ready is low while it runs. The items
// sit in a RAM with one read and one write port, and every list walk reads one
// entry per cycle. Set, failed commands and the unused code finish straight
// from the idle state; get reads one entry; find and remove_all walk the whole
// list; erase_at and insert_at shift the entries from the position on;
// insert_sorted scans for its slot, then shifts the entries from that slot up.
//
// A finished result waits in the output register while the receiver stalls;
// the sequencer holds at its last step until the register frees and no new
// command is taken before then. Reset empties the list (count zero) and drops
// any pending result; the RAM contents are left as they are, since entries at
// or beyond the count are never read. Depends on pls_pkg, pls_seq, pls_ram.
module positional_list_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [pls_pkg::CMD_W-1:0]         i_command,
    input  logic [pls_pkg::POS_W-1:0]         i_position,
    input  logic signed [pls_pkg::DATA_W-1:0] i_item_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_ok,
    output logic signed [pls_pkg::IDX_W-1:0]  o_index_result,
    output logic signed [pls_pkg::DATA_W-1:0] o_read_value,
    output logic [pls_pkg::CNT_W-1:0]         o_item_count,
    output logic                              o_is_empty
);

    pls_pkg::t_ram_req ram_req;
    pls_pkg::t_data    ram_rdata;

    // Sequencer with compare unit and result register
    pls_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_position     (i_position),
        .i_item_value   (i_item_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ok           (o_ok),
        .o_index_result (o_index_result),
        .o_read_value   (o_read_value),
        .o_item_count   (o_item_count),
        .o_is_empty     (o_is_empty),
        .o_ram_req      (ram_req),
        .i_ram_rdata    (ram_rdata)
    );

    // Item storage
    pls_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule

[hw/rtl/pls_checker.sv]
// Port-level checks for the positional list store, bound to the top level.
// Depends on pls_pkg and positional_list_store.
module pls_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic                              o_ok,
    input logic signed [pls_pkg::IDX_W-1:0]  o_index_result,
    input logic signed [pls_pkg::DATA_W-1:0] o_read_value,
    input logic [pls_pkg::CNT_W-1:0]         o_item_count,
    input logic                              o_is_empty
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_ok)
            && $stable(o_index_result) && $stable(o_read_value)
            && $stable(o_item_count))
        else $error("result word changed while stalled");

    // No command is taken while a result word is stuck
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(o_out_valid && !i_out_ready))
        else $error("input ready while result word stalled");

    // Empty flag tracks the count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_item_count == '0)))
        else $error("empty flag disagrees with count");

    // Count never exceeds capacity
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_item_count <= pls_pkg::CNT_W'(pls_pkg::CAPACITY)))
        else $error("count beyond capacity");

    // A failed command reads nothing
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> (o_read_value == '0))
        else $error("read value on failed command");

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);

[test/testbench.sv]
// Self-checking testbench for positional_list_store: a stimulus table, then random command
// words under several idle patterns, checked against a mirror list kept in the testbench.
// Depends on pls_pkg and the positional_list_store RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pls_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    // Idle patterns for the two channels
    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int DRAIN_WAIT  = 2 * CAPACITY + 100;

    typedef struct packed {
        logic                     ok;
        logic signed [IDX_W-1:0]  idx;
        logic signed [DATA_W-1:0] rd;
        logic [CNT_W-1:0]         cnt;
        logic                     empty;
    } t_list_result;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        bit                typed;
        t_list_result      want;
    } t_table_step;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [CMD_W-1:0]         i_command;
    logic [POS_W-1:0]         i_position;
    logic signed [DATA_W-1:0] i_item_value;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic                     o_ok;
    logic signed [IDX_W-1:0]  o_index_result;
    logic signed [DATA_W-1:0] o_read_value;
    logic [CNT_W-1:0]         o_item_count;
    logic                     o_is_empty;

    // Mirror of the list contents and the results still to come
    logic [DATA_W-1:0] list_mirror [CAPACITY];
    int unsigned       mirror_count;
    t_list_result      pending_results [$];
    t_table_step       step_table [$];

    int mismatch_count;
    int idle_mode;
    int hold_off_left;
    int cycle_count;

    positional_list_store uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_position     (i_position),
        .i_item_value   (i_item_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ok           (o_ok),
        .o_index_result (o_index_result),
        .o_read_value   (o_read_value),
        .o_item_count   (o_item_count),
        .o_is_empty     (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Open a slot at pos and store val there
    task automatic shift_in_item(input int unsigned pos, input logic [DATA_W-1:0] val);
        for (int unsigned i = mirror_count; i > pos; i--)
            list_mirror[i] = list_mirror[i - 1];
        list_mirror[pos] = val;
        mirror_count++;
    endtask

    // Apply one command to the mirror list and form its result word
    task automatic apply_list_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                      input logic [DATA_W-1:0] val, output t_list_result res);
        int unsigned p;
        int unsigned kept;
        p = pos;
        res = '0;
        case (cmd)
            CMD_INSERT_AT: begin
                if (mirror_count < CAPACITY && p <= mirror_count) begin
                    shift_in_item(p, val);
                    res.ok = 1'b1;
                end
            end
            CMD_INSERT_SORTED: begin
                if (mirror_count >= CAPACITY) begin
                    res.idx = IDX_NONE;
                end else begin
                    p = 0;
                    while (p < mirror_count && $signed(val) > $signed(list_mirror[p]))
                        p++;
                    shift_in_item(p, val);
                    res.idx = IDX_W'(p);
                    res.ok  = 1'b1;
                end
            end
            CMD_ERASE_AT: begin
                if (p < mirror_count) begin
                    for (int unsigned i = p; i + 1 < mirror_count; i++)
                        list_mirror[i] = list_mirror[i + 1];
                    mirror_count--;
                    res.ok = 1'b1;
                end
            end
            CMD_REMOVE_ALL: begin
                kept = 0;
                for (int unsigned i = 0; i < mirror_count; i++) begin
                    if (list_mirror[i] != val) begin
                        list_mirror[kept] = list_mirror[i];
                        kept++;
                    end
                end
                res.idx = IDX_W'(mirror_count - kept);
                mirror_count = kept;
                res.ok = 1'b1;
            end
            CMD_GET: begin
                if (p < mirror_count) begin
                    res.rd = list_mirror[p];
                    res.ok = 1'b1;
                end
            end
            CMD_SET: begin
                if (p < mirror_count) begin
                    list_mirror[p] = val;
                    res.ok = 1'b1;
                end
            end
            CMD_FIND: begin
                res.idx = IDX_NONE;
                for (int unsigned i = 0; i < mirror_count; i++)
                    if (list_mirror[i] == val)
                        res.idx = IDX_W'(i);
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.cnt   = CNT_W'(mirror_count);
        res.empty = (mirror_count == 0);
    endtask

    function automatic int sender_idle_pct();
        return (idle_mode == IDLE_SENDER) ? 58 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    endfunction

    function automatic int receiver_stall_pct();
        return (idle_mode == IDLE_RECEIVER) ? 58 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    endfunction

    // Offer one command word, wait for accept, then record what should come back.
    // Called and returns at a falling edge.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] val, input bit use_typed,
                             input t_list_result typed_want);
        t_list_result predicted;
        int pct;
        pct = sender_idle_pct();
        if (pct > 0 && $urandom_range(0, 99) < pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < pct);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_position   <= pos;
        i_item_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        apply_list_command(cmd, pos, val, predicted);
        pending_results.push_back(use_typed ? typed_want : predicted);
        @(negedge i_clk);
    endtask

    function automatic t_table_step typed_step(
        input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] val,
        input logic ok, input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] rd,
        input logic [CNT_W-1:0] cnt, input logic empty);
        t_table_step s;
        s.cmd   = cmd;
        s.pos   = pos;
        s.val   = val;
        s.typed = 1'b1;
        s.want  = '{ok, idx, rd, cnt, empty};
        return s;
    endfunction

    function automatic t_table_step predicted_step(
        input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] val);
        t_table_step s;
        s.cmd   = cmd;
        s.pos   = pos;
        s.val   = val;
        s.typed = 1'b0;
        s.want  = '0;
        return s;
    endfunction

    // Mostly a few values that repeat, so find and remove_all hit, plus the extremes
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return DATA_W'($urandom_range(0, 3));
            4, 5:    return -DATA_W'($urandom_range(1, 3));
            default: return $urandom();
        endcase
    endfunction

    // Random word that keeps the list near size_cap; most positions in range
    task automatic pick_word(input int unsigned size_cap, output logic [CMD_W-1:0] cmd,
                             output logic [POS_W-1:0] pos, output logic [DATA_W-1:0] val);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            cmd = CMD_UNUSED;
        else if (mirror_count >= size_cap && roll < 60)
            cmd = CMD_ERASE_AT;
        else
            cmd = CMD_W'($urandom_range(0, 6));
        if ($urandom_range(0, 99) < 15)
            pos = POS_W'($urandom_range(0, 511));
        else if (cmd == CMD_INSERT_AT)
            pos = POS_W'($urandom_range(0, mirror_count));
        else if (mirror_count == 0)
            pos = '0;
        else
            pos = POS_W'($urandom_range(0, mirror_count - 1));
        val = pick_value();
    endtask

    // Receiver side: random stalls, and a long hold-off when one is requested
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                i_out_ready <= 1'b0;
                hold_off_left--;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
            end
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected, ok %0d idx %0d count %0d",
                         $time, o_ok, o_index_result, o_item_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok) begin
                    $display("%0t: ok expected %0d actual %0d", $time, want.ok, o_ok);
                    mismatch_count++;
                end
                if (o_index_result !== want.idx) begin
                    $display("%0t: index_result expected %0d actual %0d",
                             $time, want.idx, o_index_result);
                    mismatch_count++;
                end
                if (o_read_value !== want.rd) begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, want.rd, o_read_value);
                    mismatch_count++;
                end
                if (o_item_count !== want.cnt) begin
                    $display("%0t: item_count expected %0d actual %0d",
                             $time, want.cnt, o_item_count);
                    mismatch_count++;
                end
                if (o_is_empty !== want.empty) begin
                    $display("%0t: is_empty expected %0d actual %0d",
                             $time, want.empty, o_is_empty);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d result words outstanding", $time, pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence
    initial begin
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        int unsigned       size_cap;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = '0;
        i_position     = '0;
        i_item_value   = '0;
        mismatch_count = 0;
        idle_mode      = IDLE_NONE;
        hold_off_left  = 0;
        mirror_count   = 0;
        size_cap       = 4;
        for (int i = 0; i < CAPACITY; i++)
            list_mirror[i] = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table: empty-list cases, bad positions, unused code, extremes
        step_table.push_back(typed_step(CMD_GET, 9'd0, 32'd0, 1'b0, '0, '0, 9'd0, 1'b1));
        step_table.push_back(typed_step(CMD_FIND, 9'd0, 32'd5, 1'b1, IDX_NONE, '0, 9'd0, 1'b1));
        step_table.push_back(typed_step(CMD_REMOVE_ALL, 9'd0, 32'd5, 1'b1, '0, '0, 9'd0, 1'b1));
        step_table.push_back(typed_step(CMD_ERASE_AT, 9'd0, 32'd0, 1'b0, '0, '0, 9'd0, 1'b1));
        step_table.push_back(typed_step(CMD_SET, 9'd0, 32'd7, 1'b0, '0, '0, 9'd0, 1'b1));
        step_table.push_back(typed_step(CMD_INSERT_AT, 9'd1, 32'd3, 1'b0, '0, '0, 9'd0, 1'b1));
        step_table.push_back(typed_step(CMD_UNUSED, 9'h1FF, 32'hFFFF_FFFF,
                                        1'b0, '0, '0, 9'd0, 1'b1));
        step_table.push_back(typed_step(CMD_INSERT_AT, 9'd0, 32'h7FFF_FFFF,
                                        1'b1, '0, '0, 9'd1, 1'b0));
        step_table.push_back(typed_step(CMD_INSERT_SORTED, 9'h1FF, 32'h8000_0000,
                                        1'b1, '0, '0, 9'd2, 1'b0));
        step_table.push_back(typed_step(CMD_INSERT_AT, 9'd2, 32'd0, 1'b1, '0, '0, 9'd3, 1'b0));
        step_table.push_back(typed_step(CMD_GET, 9'd0, 32'd0, 1'b1, '0, 32'h8000_0000,
                                        9'd3, 1'b0));
        step_table.push_back(typed_step(CMD_GET, 9'd1, 32'd0, 1'b1, '0, 32'h7FFF_FFFF,
                                        9'd3, 1'b0));
        step_table.push_back(typed_step(CMD_GET, 9'd3, 32'd0, 1'b0, '0, '0, 9'd3, 1'b0));
        step_table.push_back(typed_step(CMD_GET, 9'h1FF, 32'd0, 1'b0, '0, '0, 9'd3, 1'b0));
        // equal values go in front of the first match
        step_table.push_back(predicted_step(CMD_INSERT_SORTED, 9'd0, 32'd0));
        step_table.push_back(predicted_step(CMD_INSERT_SORTED, 9'd0, 32'd0));
        step_table.push_back(predicted_step(CMD_FIND, 9'd0, 32'd0));
        step_table.push_back(predicted_step(CMD_SET, 9'd0, 32'hFFFF_FFFF));
        step_table.push_back(predicted_step(CMD_INSERT_AT, 9'd0, 32'hFFFF_FFFF));
        step_table.push_back(predicted_step(CMD_REMOVE_ALL, 9'd0, 32'd0));
        step_table.push_back(predicted_step(CMD_ERASE_AT, 9'd2, 32'd0));
        step_table.push_back(predicted_step(CMD_ERASE_AT, 9'd2, 32'd0));
        step_table.push_back(predicted_step(CMD_ERASE_AT, 9'd0, 32'd0));
        step_table.push_back(predicted_step(CMD_REMOVE_ALL, 9'd0, 32'hFFFF_FFFF));
        step_table.push_back(predicted_step(CMD_INSERT_SORTED, 9'd0, 32'h5555_5555));
        step_table.push_back(predicted_step(CMD_INSERT_SORTED, 9'd0, 32'h7FFF_FFFF));

        foreach (step_table[i])
            send_word(step_table[i].cmd, step_table[i].pos, step_table[i].val,
                      step_table[i].typed, step_table[i].want);

        // Random words on short lists, one pass per idle pattern
        for (int mode = IDLE_NONE; mode <= IDLE_BOTH; mode++) begin
            idle_mode = mode;
            // long receiver hold-off so the block backs up onto its input
            if (mode == IDLE_NONE)
                hold_off_left = 500;
            for (int n = 0; n < 380; n++) begin
                if (n % 40 == 0)
                    size_cap = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 48)
                                                           : $urandom_range(2, 10);
                pick_word(size_cap, cmd, pos, val);
                send_word(cmd, pos, val, 1'b0, '0);
            end
        end

        // Fill the list to capacity
        idle_mode = IDLE_SENDER;
        while (mirror_count < CAPACITY) begin
            if ($urandom_range(0, 1) == 0)
                send_word(CMD_INSERT_AT, POS_W'($urandom_range(0, mirror_count)),
                          pick_value(), 1'b0, '0);
            else
                send_word(CMD_INSERT_SORTED, POS_W'($urandom_range(0, 511)),
                          pick_value(), 1'b0, '0);
        end

        // Full-list cases: rejected inserts, last entry, first bad position
        idle_mode = IDLE_RECEIVER;
        send_word(CMD_INSERT_AT, 9'd0, pick_value(), 1'b0, '0);
        send_word(CMD_INSERT_AT, 9'd256, pick_value(), 1'b0, '0);
        send_word(CMD_INSERT_SORTED, 9'd0, pick_value(), 1'b0, '0);
        send_word(CMD_GET, 9'd255, 32'd0, 1'b0, '0);
        send_word(CMD_GET, 9'd256, 32'd0, 1'b0, '0);
        send_word(CMD_SET, 9'd255, 32'h8000_0000, 1'b0, '0);
        send_word(CMD_SET, 9'd256, 32'h7FFF_FFFF, 1'b0, '0);
        send_word(CMD_FIND, 9'd0, 32'h8000_0000, 1'b0, '0);
        send_word(CMD_FIND, 9'd0, 32'd1, 1'b0, '0);
        send_word(CMD_ERASE_AT, 9'd256, 32'd0, 1'b0, '0);
        send_word(CMD_ERASE_AT, 9'd255, 32'd0, 1'b0, '0);
        send_word(CMD_INSERT_AT, 9'd255, 32'h7FFF_FFFF, 1'b0, '0);
        send_word(CMD_INSERT_SORTED, 9'd0, 32'h7FFF_FFFF, 1'b0, '0);
        send_word(CMD_GET, 9'd0, 32'd0, 1'b0, '0);

        // Drain: remove the repeating values, then erase what is left
        idle_mode = IDLE_BOTH;
        for (int k = -3; k <= 3; k++)
            send_word(CMD_REMOVE_ALL, 9'd0, DATA_W'(k), 1'b0, '0);
        send_word(CMD_REMOVE_ALL, 9'd0, 32'h8000_0000, 1'b0, '0);
        send_word(CMD_REMOVE_ALL, 9'd0, 32'h7FFF_FFFF, 1'b0, '0);
        while (mirror_count > 0)
            send_word(CMD_ERASE_AT, POS_W'($urandom_range(0, mirror_count - 1)),
                      32'd0, 1'b0, '0);
        send_word(CMD_FIND, 9'd0, 32'd0, 1'b0, '0);

        i_in_valid <= 1'b0;
        idle_mode = IDLE_NONE;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
